// ===== src/qlsm_pkg.sv =====
// Package of shared types and constants for the link quality monitor.
package qlsm_pkg;

    localparam logic [1:0] FUNC_SENT  = 2'd0;
    localparam logic [1:0] FUNC_REPLY = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [2:0] REG_MAX_RTT    = 3'd0;
    localparam logic [2:0] REG_MAX_JITTER = 3'd1;
    localparam logic [2:0] REG_MIN_PDR    = 3'd2;
    localparam logic [2:0] REG_MIN_SCORE  = 3'd3;
    localparam logic [2:0] REG_MIN_HOLD   = 3'd4;
    localparam logic [2:0] REG_CUTOFF     = 3'd5;
    localparam logic [2:0] REG_MIN_DEGR   = 3'd6;
    localparam logic [2:0] REG_WEIGHTS    = 3'd7;

    // Slot count of the probe table; the slot index is the low bits of seq, so it is a power
    // of two.
    localparam int PROBE_SLOTS = 64;

    localparam int CFG_DATA_BITS = 32;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Request into the iterative divider.
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

endpackage

// ===== src/qlsm_if.sv =====
// Valid/ready channel interfaces for probe events and tick results.
interface qlsm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] seq;
    logic [47:0] time_now_us;
    logic        sat_visible;
    modport source (output valid, func, seq, time_now_us, sat_visible, input ready);
    modport sink (input valid, func, seq, time_now_us, sat_visible, output ready);
endinterface

interface qlsm_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] qos_score;
    logic [32:0] avg_rtt_us;
    logic [31:0] avg_jitter_us;
    logic [16:0] delivery_ratio;
    logic [6:0]  sample_count;
    logic [7:0]  degrade_count;
    logic        switched;
    logic        on_satellite;
    logic        evaluated;
    modport source (output valid, qos_score, avg_rtt_us, avg_jitter_us, delivery_ratio,
        sample_count, degrade_count, switched, on_satellite, evaluated, input ready);
    modport sink (input valid, qos_score, avg_rtt_us, avg_jitter_us, delivery_ratio,
        sample_count, degrade_count, switched, on_satellite, evaluated, output ready);
endinterface

// ===== src/qlsm_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module qlsm_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  qlsm_pkg::div_req_t req,
    output qlsm_pkg::div_rsp_t rsp
);
    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]} - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

// ===== src/qos_link_switch_monitor.sv =====
// Link quality monitor: probe slot table in memory, tick statistics and switch decision.
// Each probe event (sent or reply) passes through a read of the slot memory, then a
// write-back, then the WRITE state, and then it is ready again. A tick walks all PROBE_SLOTS
// slots one per cycle through the memory's registered read port, then a second walk drops
// aged entries, then seven divisions run one after another on a shared radix-2 divider
// before the result is offered. Func 3 is dropped. After reset the slot valid flags are
// cleared by a pass over all PROBE_SLOTS slots during which no item is accepted.
module qos_link_switch_monitor
#(
    parameter int TIME_BITS   = 48
)
(
    input  logic              clk,
    input  logic              rst_n,
    qlsm_in_if.sink           in_ch,
    qlsm_out_if.source        out_ch,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [qlsm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    localparam int PROBE_SLOTS = qlsm_pkg::PROBE_SLOTS;
    localparam int IDX_BITS = $clog2(PROBE_SLOTS);
    localparam int TAG_BITS = 16 - IDX_BITS + 1;
    localparam int CNT_BITS = $clog2(PROBE_SLOTS + 1);
    // Entry: valid, rx, link, tag, tx time, rtt.
    localparam int ENT_BITS = 3 + TAG_BITS + TIME_BITS + 32;

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b00000000001,
        ST_IDLE  = 11'b00000000010,
        ST_PROBE = 11'b00000000100,
        ST_WRITE = 11'b00000001000,
        ST_STAT  = 11'b00000010000,
        ST_DROP  = 11'b00000100000,
        ST_DIV   = 11'b00001000000,
        ST_WAIT  = 11'b00010000000,
        ST_SCORE = 11'b00100000000,
        ST_DECIDE= 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic                 valid;
        logic                 rx;
        logic                 link;
        logic [TAG_BITS-1:0]  tag;
        logic [TIME_BITS-1:0] tx;
        logic [31:0]          rtt;
    } entry_t;

    // Configuration registers.
    logic [31:0] max_rtt_reg, max_jit_reg, hold_reg, cutoff_reg;
    logic [16:0] min_pdr_reg, min_score_reg;
    logic [7:0]  min_degr_reg;
    logic [23:0] weights_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rtt_reg   <= 32'd500000;
            max_jit_reg   <= 32'd100000;
            min_pdr_reg   <= 17'd58982;
            min_score_reg <= 17'd39322;
            hold_reg      <= 32'd5000000;
            cutoff_reg    <= 32'd10000000;
            min_degr_reg  <= 8'd3;
            weights_reg   <= 24'd65793;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qlsm_pkg::REG_MAX_RTT:    max_rtt_reg   <= cfg_data;
                qlsm_pkg::REG_MAX_JITTER: max_jit_reg   <= cfg_data;
                qlsm_pkg::REG_MIN_PDR:    min_pdr_reg   <= cfg_data[16:0];
                qlsm_pkg::REG_MIN_SCORE:  min_score_reg <= cfg_data[16:0];
                qlsm_pkg::REG_MIN_HOLD:   hold_reg      <= cfg_data;
                qlsm_pkg::REG_CUTOFF:     cutoff_reg    <= cfg_data;
                qlsm_pkg::REG_MIN_DEGR:   min_degr_reg  <= cfg_data[7:0];
                qlsm_pkg::REG_WEIGHTS:    weights_reg   <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Slot memory.
    logic [ENT_BITS-1:0] mem [PROBE_SLOTS];
    logic                mem_we;
    logic [IDX_BITS-1:0] mem_waddr, mem_raddr;
    entry_t              mem_wdata, rd_ent;
    logic [ENT_BITS-1:0] rd_raw;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_raw <= mem[mem_raddr];
    end
    assign rd_ent = entry_t'(rd_raw);

    state_t state_reg, state_next;
    logic [CNT_BITS-1:0] ptr_reg, ptr_next;     // read pointer of a walk
    logic                rdv_reg, rdv_next;     // read data valid during a walk
    logic [IDX_BITS-1:0] radr_reg, radr_next;   // address of the data in rd_raw

    logic [1:0]           func_reg, func_next;
    logic [IDX_BITS-1:0]  idx_reg, idx_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic                 vis_reg, vis_next;

    logic [CNT_BITS-1:0]  sent_reg, sent_next, rcv_reg, rcv_next;
    logic [CNT_BITS+31:0] rsum_reg, rsum_next, jsum_reg, jsum_next;
    logic [31:0]          prev_reg, prev_next;

    logic                 sat_reg, sat_next;
    logic [7:0]           degr_reg, degr_next;
    logic [TIME_BITS-1:0] last_reg, last_next;

    // Division results.
    logic [32:0] avg_rtt_reg, avg_rtt_next;
    logic [31:0] avg_jit_reg, avg_jit_next;
    logic [16:0] pdr_reg, pdr_next;
    logic [16:0] rp_reg, rp_next, jp_reg, jp_next, pp_reg, pp_next;
    logic [16:0] score_reg, score_next;
    logic [2:0]  dstep_reg, dstep_next;
    logic        switched_reg, switched_next;
    logic [26:0] wsum_reg, wsum_next;

    qlsm_pkg::div_req_t dreq;
    qlsm_pkg::div_rsp_t drsp;

    qlsm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [TIME_BITS-1:0] rtt_full;
    logic [31:0]          rtt_sat;
    logic [31:0]          jdiff;
    logic [TIME_BITS-1:0] cut_ext, hold_ext, lim;
    logic                 evald;
    logic [7:0]           wr, wp, wj;
    logic [9:0]           wtot;
    logic [16:0]          qv;
    logic [17:0]          qsat;
    logic [7:0]           degr_inc;

    function automatic logic [16:0] ONE_Q16_M(input logic [16:0] q);
        return qlsm_pkg::ONE_Q16 - q;
    endfunction

    assign wr = weights_reg[7:0];
    assign wp = weights_reg[15:8];
    assign wj = weights_reg[23:16];
    assign wtot = {2'b0, wr} + {2'b0, wp} + {2'b0, wj};
    assign evald = sent_reg >= CNT_BITS'(2);
    assign cut_ext = TIME_BITS'(cutoff_reg);
    assign hold_ext = TIME_BITS'(hold_reg);
    assign lim = now_reg - cut_ext;
    assign rtt_full = now_reg - rd_ent.tx;
    assign rtt_sat = (rtt_full > TIME_BITS'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : rtt_full[31:0];
    assign jdiff = (rd_ent.rtt > prev_reg) ? rd_ent.rtt - prev_reg : prev_reg - rd_ent.rtt;
    // Saturated normalization quotient, at most 65536.
    assign qsat = (drsp.quo > 64'd65536) ? 18'd65536 : drsp.quo[17:0];
    assign qv = (drsp.quo >= 64'd65536) ? 17'd0 : ONE_Q16_M(drsp.quo[16:0]);
    assign degr_inc = (degr_reg == 8'd255) ? degr_reg : degr_reg + 8'd1;

    always_comb
    begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        rdv_next = 1'b0;
        radr_next = ptr_reg[IDX_BITS-1:0];
        func_next = func_reg;
        idx_next = idx_reg;
        tag_next = tag_reg;
        now_next = now_reg;
        vis_next = vis_reg;
        sent_next = sent_reg;
        rcv_next = rcv_reg;
        rsum_next = rsum_reg;
        jsum_next = jsum_reg;
        prev_next = prev_reg;
        sat_next = sat_reg;
        degr_next = degr_reg;
        last_next = last_reg;
        avg_rtt_next = avg_rtt_reg;
        avg_jit_next = avg_jit_reg;
        pdr_next = pdr_reg;
        rp_next = rp_reg;
        jp_next = jp_reg;
        pp_next = pp_reg;
        score_next = score_reg;
        dstep_next = dstep_reg;
        switched_next = switched_reg;
        wsum_next = wsum_reg;
        mem_we = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = rd_ent;
        mem_raddr = ptr_reg[IDX_BITS-1:0];
        dreq.start = 1'b0;
        dreq.num = '0;
        dreq.den = 64'd1;
        in_ch.ready = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = ptr_reg[IDX_BITS-1:0];
                mem_wdata = '0;
                ptr_next = ptr_reg + CNT_BITS'(1);
                if (ptr_reg == CNT_BITS'(PROBE_SLOTS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                mem_raddr = in_ch.seq[IDX_BITS-1:0];
                if (in_ch.valid)
                begin
                    func_next = in_ch.func;
                    idx_next = in_ch.seq[IDX_BITS-1:0];
                    tag_next = TAG_BITS'(in_ch.seq >> IDX_BITS);
                    now_next = TIME_BITS'(in_ch.time_now_us);
                    vis_next = in_ch.sat_visible;
                    ptr_next = '0;
                    sent_next = '0;
                    rcv_next = '0;
                    rsum_next = '0;
                    jsum_next = '0;
                    prev_next = '0;
                    case (in_ch.func)
                        qlsm_pkg::FUNC_SENT, qlsm_pkg::FUNC_REPLY: state_next = ST_PROBE;
                        qlsm_pkg::FUNC_TICK: state_next = ST_STAT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PROBE:
            begin
                // Slot entry is now in the read register.
                state_next = ST_WRITE;
                if (func_reg == qlsm_pkg::FUNC_SENT)
                begin
                    mem_we = 1'b1;
                    mem_wdata.valid = 1'b1;
                    mem_wdata.rx = 1'b0;
                    mem_wdata.link = sat_reg;
                    mem_wdata.tag = tag_reg;
                    mem_wdata.tx = now_reg;
                    mem_wdata.rtt = '0;
                end
                else if (rd_ent.valid && rd_ent.tag == tag_reg)
                begin
                    mem_we = 1'b1;
                    mem_wdata.rx = 1'b1;
                    mem_wdata.rtt = rtt_sat;
                end
            end
            ST_WRITE:
                state_next = ST_IDLE;
            ST_STAT, ST_DROP:
            begin
                if (ptr_reg != CNT_BITS'(PROBE_SLOTS))
                    ptr_next = ptr_reg + CNT_BITS'(1);
                rdv_next = ptr_reg != CNT_BITS'(PROBE_SLOTS);
                if (rdv_reg)
                begin
                    if (state_reg == ST_STAT)
                    begin
                        if (rd_ent.valid && rd_ent.link == sat_reg)
                        begin
                            sent_next = sent_reg + CNT_BITS'(1);
                            if (rd_ent.rx)
                            begin
                                if (rcv_reg != '0)
                                    jsum_next = jsum_reg + (CNT_BITS+32)'(jdiff);
                                prev_next = rd_ent.rtt;
                                rsum_next = rsum_reg + (CNT_BITS+32)'(rd_ent.rtt);
                                rcv_next = rcv_reg + CNT_BITS'(1);
                            end
                        end
                    end
                    else if (cut_ext <= now_reg && rd_ent.valid && rd_ent.tx < lim)
                    begin
                        mem_we = 1'b1;
                        mem_waddr = radr_reg;
                        mem_wdata.valid = 1'b0;
                    end
                end
                if (!rdv_reg && ptr_reg == CNT_BITS'(PROBE_SLOTS))
                begin
                    ptr_next = '0;
                    state_next = (state_reg == ST_STAT) ? ST_DROP : ST_DIV;
                    dstep_next = '0;
                end
            end
            ST_DIV:
            begin
                // Launch the division of the current step.
                dreq.start = 1'b1;
                state_next = ST_WAIT;
                case (dstep_reg)
                    3'd0:
                    begin
                        dreq.num = 64'(rsum_reg);
                        dreq.den = (rcv_reg == '0) ? 64'd1 : 64'(rcv_reg);
                    end
                    3'd1:
                    begin
                        dreq.num = 64'(jsum_reg);
                        dreq.den = (rcv_reg < CNT_BITS'(2)) ? 64'd1
                                                            : 64'(rcv_reg - CNT_BITS'(1));
                    end
                    3'd2:
                    begin
                        dreq.num = 64'(rcv_reg) << 16;
                        dreq.den = (sent_reg == '0) ? 64'd1 : 64'(sent_reg);
                    end
                    3'd3:
                    begin
                        dreq.num = 64'(avg_rtt_reg) << 16;
                        dreq.den = (max_rtt_reg == '0) ? 64'd1 : 64'(max_rtt_reg);
                    end
                    3'd4:
                    begin
                        dreq.num = 64'(avg_jit_reg) << 16;
                        dreq.den = (max_jit_reg == '0) ? 64'd1 : 64'(max_jit_reg);
                    end
                    3'd5:
                    begin
                        dreq.num = 64'(pdr_reg) << 16;
                        dreq.den = (min_pdr_reg == '0) ? 64'd1 : 64'(min_pdr_reg);
                    end
                    3'd6:
                    begin
                        dreq.num = 64'(wsum_reg);
                        dreq.den = (wtot == '0) ? 64'd1 : 64'(wtot);
                    end
                    default: ;
                endcase
            end
            ST_WAIT:
            begin
                if (drsp.done)
                begin
                    dstep_next = dstep_reg + 3'd1;
                    state_next = ST_DIV;
                    case (dstep_reg)
                        3'd0:
                            if (sent_reg == '0)
                                avg_rtt_next = '0;
                            else if (rcv_reg == '0)
                                avg_rtt_next = {max_rtt_reg, 1'b0};
                            else
                                avg_rtt_next = drsp.quo[32:0];
                        3'd1:
                            avg_jit_next = (rcv_reg < CNT_BITS'(2)) ? '0 : drsp.quo[31:0];
                        3'd2:
                            pdr_next = (sent_reg == '0) ? qlsm_pkg::ONE_Q16 : drsp.quo[16:0];
                        3'd3:
                            rp_next = (max_rtt_reg == '0) ? '0 : qv;
                        3'd4:
                            jp_next = (max_jit_reg == '0) ? '0 : qv;
                        3'd5:
                        begin
                            pp_next = (min_pdr_reg == '0) ? qlsm_pkg::ONE_Q16 : qsat[16:0];
                            state_next = ST_SCORE;
                            wsum_next = '0;
                        end
                        default:
                        begin
                            score_next = (evald && pdr_reg != '0 && wtot != '0)
                                       ? drsp.quo[16:0] : '0;
                            state_next = ST_DECIDE;
                        end
                    endcase
                end
            end
            ST_SCORE:
            begin
                // One product per cycle into the weighted sum.
                case (dstep_reg)
                    3'd6:
                    begin
                        wsum_next = 27'(rp_reg * wr);
                        dstep_next = 3'd7;
                    end
                    3'd7:
                    begin
                        wsum_next = wsum_reg + 27'(pp_reg * wp);
                        dstep_next = 3'd0;
                    end
                    default:
                    begin
                        wsum_next = wsum_reg + 27'(jp_reg * wj);
                        dstep_next = 3'd6;
                        state_next = ST_DIV;
                    end
                endcase
            end
            ST_DECIDE:
            begin
                switched_next = 1'b0;
                state_next = ST_OUT;
                if (evald)
                begin
                    if ({8'd0, score_reg} < {8'd0, min_score_reg})
                    begin
                        degr_next = degr_inc;
                        if (degr_inc >= min_degr_reg && now_reg >= last_reg
                            && (now_reg - last_reg) >= hold_ext && (sat_reg || vis_reg))
                        begin
                            sat_next = !sat_reg;
                            last_next = now_reg;
                            degr_next = '0;
                            switched_next = 1'b1;
                        end
                    end
                    else
                        degr_next = '0;
                end
            end
            ST_OUT:
                if (out_ch.ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ptr_reg   <= '0;
            rdv_reg   <= 1'b0;
            sat_reg   <= 1'b0;
            degr_reg  <= '0;
            last_reg  <= '0;
            dstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            rdv_reg   <= rdv_next;
            sat_reg   <= sat_next;
            degr_reg  <= degr_next;
            last_reg  <= last_next;
            dstep_reg <= dstep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radr_reg <= radr_next;
        func_reg <= func_next;
        idx_reg <= idx_next;
        tag_reg <= tag_next;
        now_reg <= now_next;
        vis_reg <= vis_next;
        sent_reg <= sent_next;
        rcv_reg <= rcv_next;
        rsum_reg <= rsum_next;
        jsum_reg <= jsum_next;
        prev_reg <= prev_next;
        avg_rtt_reg <= avg_rtt_next;
        avg_jit_reg <= avg_jit_next;
        pdr_reg <= pdr_next;
        rp_reg <= rp_next;
        jp_reg <= jp_next;
        pp_reg <= pp_next;
        score_reg <= score_next;
        switched_reg <= switched_next;
        wsum_reg <= wsum_next;
    end

    assign out_ch.valid = state_reg == ST_OUT;
    assign out_ch.qos_score = score_reg;
    assign out_ch.avg_rtt_us = avg_rtt_reg;
    assign out_ch.avg_jitter_us = avg_jit_reg;
    assign out_ch.delivery_ratio = pdr_reg;
    assign out_ch.sample_count = 7'(sent_reg);
    assign out_ch.degrade_count = degr_reg;
    assign out_ch.switched = switched_reg;
    assign out_ch.on_satellite = sat_reg;
    assign out_ch.evaluated = evald;
endmodule

// ===== src/qlsm_checker.sv =====
// Port-level checker for the link quality monitor, bound to the top level.
module qlsm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] qos_score,
    input logic [16:0] delivery_ratio,
    input logic [6:0]  sample_count,
    input logic        switched,
    input logic        evaluated,
    input logic [7:0]  degrade_count
);
    // No new request is taken while a result waits.
    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request accepted while result pending");

    // A held result does not change.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(qos_score) && $stable(sample_count))
        else $error("pending result changed");

    // A switch clears the degradation count and needs an evaluation.
    a_switch_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && switched |-> evaluated && degrade_count == 8'd0)
        else $error("switch without evaluation or count kept");

    // Without evaluation the score is zero.
    a_score_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evaluated |-> qos_score == 17'd0 && sample_count < 7'd2)
        else $error("score given without evaluation");

    // Ratio never exceeds one.
    a_pdr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> delivery_ratio <= 17'd65536)
        else $error("delivery ratio out of range");
endmodule

bind qos_link_switch_monitor qlsm_checker u_qlsm_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .qos_score(out_ch.qos_score), .delivery_ratio(out_ch.delivery_ratio),
    .sample_count(out_ch.sample_count), .switched(out_ch.switched),
    .evaluated(out_ch.evaluated), .degrade_count(out_ch.degrade_count)
);

// ===== bench/qlsm_checker.sv =====
// Checker for the link quality monitor: predicts each tick result and compares it.
`timescale 1ns / 1ps
module qlsm_tb_checker
(
    input  logic        clk,
    input  logic        rst_n,
    qlsm_in_if          in_ch,
    qlsm_out_if         out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fails,
    output int          pending,
    output int          ticks_checked,
    output int          requests_seen
);

    localparam int SLOTS = 64;

    typedef struct packed {
        logic [16:0] qos_score;
        logic [32:0] avg_rtt_us;
        logic [31:0] avg_jitter_us;
        logic [16:0] delivery_ratio;
        logic [6:0]  sample_count;
        logic [7:0]  degrade_count;
        logic        switched;
        logic        on_satellite;
        logic        evaluated;
    } tick_result_t;

    tick_result_t tick_q[$];

    // Register copies.
    logic [31:0] lim_rtt, lim_jitter, hold_us, age_cutoff;
    logic [16:0] pdr_floor, score_floor;
    logic [7:0]  degr_needed;
    logic [23:0] weights;

    // Slot table copy.
    logic        slot_used [SLOTS];
    logic        slot_answered [SLOTS];
    logic        slot_on_sat [SLOTS];
    logic [9:0]  slot_tag [SLOTS];
    logic [47:0] slot_sent_at [SLOTS];
    logic [31:0] slot_rtt [SLOTS];
    logic        on_sat;
    logic [7:0]  degr_run;
    logic [47:0] last_switch;

    function automatic logic [63:0] quality_part(logic [63:0] avg, logic [31:0] lim);
        logic [63:0] r;
        if (lim == 0)
            return 64'd0;
        r = (avg * 64'd65536) / {32'd0, lim};
        if (r >= 64'd65536)
            return 64'd0;
        return 64'd65536 - r;
    endfunction

    task automatic apply_request(logic [1:0] func, logic [15:0] seq, logic [47:0] now,
                                 logic vis);
        int          idx;
        logic [63:0] sent, rcv, rsum, jsum, prev, r, avg_rtt, avg_jit, pdr, score;
        logic [63:0] wr, wp, wj, tot, rp, jp, pp, dt;
        logic [47:0] lim;
        logic        ev, sw;
        tick_result_t res;
        idx = seq % SLOTS;
        if (func == qlsm_pkg::FUNC_SENT) begin
            slot_used[idx] = 1'b1;
            slot_answered[idx] = 1'b0;
            slot_on_sat[idx] = on_sat;
            slot_tag[idx] = seq[15:6];
            slot_sent_at[idx] = now;
            slot_rtt[idx] = 32'd0;
        end
        else if (func == qlsm_pkg::FUNC_REPLY) begin
            if (slot_used[idx] && slot_tag[idx] == seq[15:6]) begin
                dt = {16'd0, now - slot_sent_at[idx]};
                slot_rtt[idx] = (dt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dt[31:0];
                slot_answered[idx] = 1'b1;
            end
        end
        else if (func == qlsm_pkg::FUNC_TICK) begin
            sent = 0; rcv = 0; rsum = 0; jsum = 0; prev = 0;
            avg_rtt = 0; avg_jit = 0; pdr = 64'd65536; score = 0; sw = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_used[i] && slot_on_sat[i] == on_sat) begin
                    sent++;
                    if (slot_answered[i]) begin
                        r = {32'd0, slot_rtt[i]};
                        if (rcv > 0)
                            jsum += (r > prev) ? r - prev : prev - r;
                        prev = r;
                        rsum += r;
                        rcv++;
                    end
                end
            end
            if (sent > 0 && rcv == 0)
                avg_rtt = 64'd2 * {32'd0, lim_rtt};
            else if (rcv > 0)
                avg_rtt = rsum / rcv;
            if (rcv >= 2)
                avg_jit = jsum / (rcv - 1);
            if (sent > 0)
                pdr = (rcv * 64'd65536) / sent;
            if ({16'd0, age_cutoff} <= now) begin
                lim = now - {16'd0, age_cutoff};
                for (int i = 0; i < SLOTS; i++)
                    if (slot_used[i] && slot_sent_at[i] < lim)
                        slot_used[i] = 1'b0;
            end
            ev = (sent >= 2);
            wr = {56'd0, weights[7:0]};
            wp = {56'd0, weights[15:8]};
            wj = {56'd0, weights[23:16]};
            tot = wr + wp + wj;
            if (ev && pdr != 0 && tot != 0) begin
                rp = quality_part(avg_rtt, lim_rtt);
                jp = quality_part(avg_jit, lim_jitter);
                pp = (pdr_floor == 0) ? 64'd65536 : (pdr * 64'd65536) / {47'd0, pdr_floor};
                if (pp > 64'd65536)
                    pp = 64'd65536;
                score = (rp * wr + pp * wp + jp * wj) / tot;
            end
            if (ev) begin
                if (score < {47'd0, score_floor}) begin
                    if (degr_run != 8'd255)
                        degr_run++;
                    // The hold counts from the last switch and fails if time went back.
                    if (degr_run >= degr_needed && now >= last_switch
                        && (now - last_switch) >= {16'd0, hold_us} && (on_sat || vis)) begin
                        on_sat = !on_sat;
                        last_switch = now;
                        degr_run = 8'd0;
                        sw = 1'b1;
                    end
                end
                else begin
                    degr_run = 8'd0;
                end
            end
            res.qos_score = score[16:0];
            res.avg_rtt_us = avg_rtt[32:0];
            res.avg_jitter_us = avg_jit[31:0];
            res.delivery_ratio = pdr[16:0];
            res.sample_count = sent[6:0];
            res.degrade_count = degr_run;
            res.switched = sw;
            res.on_satellite = on_sat;
            res.evaluated = ev;
            tick_q = {tick_q, res};
        end
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t e;
        if (!rst_n) begin
            lim_rtt = 32'd500000; lim_jitter = 32'd100000; pdr_floor = 17'd58982;
            score_floor = 17'd39322; hold_us = 32'd5000000; age_cutoff = 32'd10000000;
            degr_needed = 8'd3; weights = 24'd65793;
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i] = 1'b0;
                slot_answered[i] = 1'b0;
                slot_on_sat[i] = 1'b0;
                slot_tag[i] = '0;
                slot_sent_at[i] = '0;
                slot_rtt[i] = '0;
            end
            on_sat = 1'b0;
            degr_run = 8'd0;
            last_switch = '0;
            tick_q.delete();
            fails = 0;
            ticks_checked = 0;
            requests_seen = 0;
            pending <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    qlsm_pkg::REG_MAX_RTT:    lim_rtt = cfg_data;
                    qlsm_pkg::REG_MAX_JITTER: lim_jitter = cfg_data;
                    qlsm_pkg::REG_MIN_PDR:    pdr_floor = cfg_data[16:0];
                    qlsm_pkg::REG_MIN_SCORE:  score_floor = cfg_data[16:0];
                    qlsm_pkg::REG_MIN_HOLD:   hold_us = cfg_data;
                    qlsm_pkg::REG_CUTOFF:     age_cutoff = cfg_data;
                    qlsm_pkg::REG_MIN_DEGR:   degr_needed = cfg_data[7:0];
                    qlsm_pkg::REG_WEIGHTS:    weights = cfg_data[23:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                requests_seen++;
                apply_request(in_ch.func, in_ch.seq, in_ch.time_now_us, in_ch.sat_visible);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (tick_q.size() == 0) begin
                    $error("tick result with no request waiting for one");
                    fails++;
                end
                else begin
                    e = tick_q.pop_front();
                    ticks_checked++;
                    check_field("qos_score", e.qos_score, out_ch.qos_score);
                    check_field("avg_rtt_us", e.avg_rtt_us, out_ch.avg_rtt_us);
                    check_field("avg_jitter_us", e.avg_jitter_us, out_ch.avg_jitter_us);
                    check_field("delivery_ratio", e.delivery_ratio, out_ch.delivery_ratio);
                    check_field("sample_count", e.sample_count, out_ch.sample_count);
                    check_field("degrade_count", e.degrade_count, out_ch.degrade_count);
                    check_field("switched", e.switched, out_ch.switched);
                    check_field("on_satellite", e.on_satellite, out_ch.on_satellite);
                    check_field("evaluated", e.evaluated, out_ch.evaluated);
                end
            end
            pending <= tick_q.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the link quality monitor bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 700;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          fails, pending, ticks_checked, requests_seen;
    int          idle_mode = 0;
    int          hold_left = 0;
    int          quiet = 0;
    logic [47:0] now_t;
    logic [15:0] next_seq;
    logic [15:0] recent[$];

    qlsm_in_if  in_ch();
    qlsm_out_if out_ch();

    qos_link_switch_monitor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    qlsm_tb_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fails         (fails),
        .pending       (pending),
        .ticks_checked (ticks_checked),
        .requests_seen (requests_seen)
    );

    always #2 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.func = qlsm_pkg::FUNC_SENT;
        in_ch.seq = '0;
        in_ch.time_now_us = '0;
        in_ch.sat_visible = 1'b0;
        out_ch.ready = 1'b0;
    end

    // Receiver side: random stalls by mode, plus a long hold-off on demand.
    always @(posedge clk)
    begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (idle_mode == 2)
            out_ch.ready <= ($urandom_range(99) >= 88);
        else if (idle_mode == 3)
            out_ch.ready <= ($urandom_range(99) >= 7);
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("Timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send(logic [1:0] func, logic [15:0] seq, logic [47:0] t, logic vis);
        int idle_pct;
        in_ch.valid <= 1'b1;
        in_ch.func <= func;
        in_ch.seq <= seq;
        in_ch.time_now_us <= t;
        in_ch.sat_visible <= vis;
        do
            @(posedge clk);
        while (!in_ch.ready);
        idle_pct = (idle_mode == 1) ? 88 : (idle_mode == 3) ? 7 : 0;
        if ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Lets the block finish everything in flight before registers change.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(int phase);
        logic [31:0] v[8];
        case (phase)
            0: v = '{32'd500000, 32'd100000, 32'd58982, 32'd39322, 32'd5000000,
                     32'd10000000, 32'd3, 32'd65793};
            1: v = '{32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0};
            2: v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65536, 32'd65536, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'd255, 32'hFF_FFFF};
            default: v = '{$urandom_range(1000000, 1000), $urandom_range(300000, 100),
                           $urandom_range(65536, 1), $urandom_range(65536, 0),
                           $urandom_range(3000000, 0), $urandom_range(30000000, 200000),
                           $urandom_range(4, 0), $urandom_range(24'hFF_FFFF, 0)};
        endcase
        write_reg(qlsm_pkg::REG_MAX_RTT, v[0]);
        write_reg(qlsm_pkg::REG_MAX_JITTER, v[1]);
        write_reg(qlsm_pkg::REG_MIN_PDR, v[2]);
        write_reg(qlsm_pkg::REG_MIN_SCORE, v[3]);
        write_reg(qlsm_pkg::REG_MIN_HOLD, v[4]);
        write_reg(qlsm_pkg::REG_CUTOFF, v[5]);
        write_reg(qlsm_pkg::REG_MIN_DEGR, v[6]);
        write_reg(qlsm_pkg::REG_WEIGHTS, v[7]);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly sent/reply pairs against a running clock, with ticks, noise and time jumps.
    task automatic random_request();
        int          pick;
        logic [15:0] s;
        pick = $urandom_range(99);
        if (pick < 38 || (pick < 73 && recent.size() == 0) || pick >= 97) begin
            if (pick >= 97)
                now_t = 48'({$urandom, $urandom});
            now_t += 48'($urandom_range(20000));
            send(qlsm_pkg::FUNC_SENT, next_seq, now_t, 1'($urandom_range(1)));
            recent = {recent, next_seq};
            if (recent.size() > 20)
                void'(recent.pop_front());
            next_seq++;
        end
        else if (pick < 73) begin
            s = recent[$urandom_range(recent.size() - 1)];
            now_t += 48'(($urandom_range(9) == 0) ? $urandom_range(2000000)
                                                   : $urandom_range(300000));
            send(qlsm_pkg::FUNC_REPLY, s, now_t, 1'($urandom_range(1)));
        end
        else if (pick < 89) begin
            now_t += 48'($urandom_range(2000000));
            send(qlsm_pkg::FUNC_TICK, 16'($urandom), now_t, 1'($urandom_range(1)));
        end
        else if (pick < 93) begin
            send(FUNC_UNUSED, 16'($urandom), 48'({$urandom, $urandom}),
                 1'($urandom_range(1)));
        end
        else begin
            send(qlsm_pkg::FUNC_REPLY, 16'($urandom), now_t + 48'($urandom_range(100000)),
                 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(0);
        // Empty table, one unanswered entry, repeated and unmatched replies.
        send(qlsm_pkg::FUNC_TICK, 16'd0, 48'd1000, 1'b0);
        send(qlsm_pkg::FUNC_SENT, 16'h0000, 48'd1000, 1'b0);
        send(qlsm_pkg::FUNC_TICK, 16'd0, 48'd1500, 1'b0);
        send(qlsm_pkg::FUNC_SENT, 16'h0001, 48'd2000, 1'b1);
        send(qlsm_pkg::FUNC_REPLY, 16'h0000, 48'd3000, 1'b0);
        send(qlsm_pkg::FUNC_REPLY, 16'h0000, 48'd3500, 1'b0);
        send(qlsm_pkg::FUNC_REPLY, 16'h0040, 48'd3600, 1'b0);
        send(qlsm_pkg::FUNC_REPLY, 16'h0005, 48'd3700, 1'b0);
        // Same slot, new tag: the old probe is overwritten.
        send(qlsm_pkg::FUNC_SENT, 16'h0041, 48'd4000, 1'b0);
        send(qlsm_pkg::FUNC_REPLY, 16'h0001, 48'd4100, 1'b0);
        send(qlsm_pkg::FUNC_REPLY, 16'h0041, 48'd900000, 1'b0);
        send(qlsm_pkg::FUNC_TICK, 16'hFFFF, 48'd950000, 1'b1);
        // A reply more than 2^32 us later saturates the round trip time.
        send(qlsm_pkg::FUNC_SENT, 16'h0002, 48'd5000, 1'b0);
        send(qlsm_pkg::FUNC_REPLY, 16'h0002, 48'h2_0000_5000, 1'b0);
        send(FUNC_UNUSED, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        send(qlsm_pkg::FUNC_SENT, 16'hFFFF, 48'hFFFF_FFFF_FFF0, 1'b1);
        send(qlsm_pkg::FUNC_REPLY, 16'hFFFF, 48'd5, 1'b1);
        send(qlsm_pkg::FUNC_TICK, 16'd0, 48'hFFFF_FFFF_FFFF, 1'b1);
        send(qlsm_pkg::FUNC_TICK, 16'd0, 48'hFFFF_FFFF_FFFF, 1'b1);
        send(qlsm_pkg::FUNC_TICK, 16'd0, 48'hFFFF_FFFF_FFFF, 1'b1);
        send(qlsm_pkg::FUNC_TICK, 16'd0, 48'd0, 1'b0);
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            configure(phase);
            now_t = 48'({$urandom_range(16'hFFFF), $urandom} >> $urandom_range(24));
            next_seq = 16'($urandom);
            recent.delete();
            idle_mode = phase % 4;
            if (phase == 1)
                hold_left = 3000;
            for (int n = 0; n < 90; n++) begin
                if (n == 45)
                    idle_mode = (phase + 2) % 4;
                random_request();
            end
            settle();
        end

        $display("Run covered %0d requests and %0d tick results over six register settings,",
                 requests_seen, ticks_checked);
        $display("with sender gaps, receiver stalls and one long receiver hold-off.");
        if (fails == 0 && pending == 0)
            $display("*** PASSED ***");
        else begin
            if (pending != 0)
                $error("%0d tick results never arrived", pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/qlsm_pkg.sv
src/qlsm_if.sv
src/qlsm_div.sv
src/qos_link_switch_monitor.sv
src/qlsm_checker.sv
bench/qlsm_checker.sv
bench/testbench.sv
